FILE: rtl/pdstep_pkg.sv
`timescale 1ns / 1ps
package pdstep_pkg;

  // Field widths
  localparam int DIR_W  = 24;
  localparam int POS_W  = 32;
  localparam int YAW_W  = 16;
  localparam int STEP_W = 21;
  localparam int UPS_W  = 20;
  localparam int DIST_W = UPS_W + STEP_W;
  localparam int DL_W   = STEP_W;
  localparam int DH_W   = DIST_W - DL_W;
  localparam int SQ_W   = 2 * DIR_W;
  localparam int PPL_W  = DIR_W + DL_W;
  localparam int PPH_W  = DIR_W + DH_W;
  localparam int NUM_W  = 64;

  // Square root: 64-bit radicand, 32-bit root
  localparam int RAD_W  = 64;
  localparam int RAD_SH = RAD_W - SQ_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  // Division: divisor is root times 64, quotient below 2^27
  localparam int DEN_SH = 6;
  localparam int DEN_W  = ROOT_W + DEN_SH;
  localparam int Q_W    = 27;

  // CORDIC datapath
  localparam int COR_W  = 44;
  localparam int COR_SH = 17;
  localparam int ACC_W  = 64;
  localparam int YAW_SH = 47;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENABLED   = 2'd0,
    CFG_UPS       = 2'd1,
    CFG_MAX_STEP  = 2'd2,
    CFG_ALIGN_YAW = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_INIT = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  // Per-request data that travels alongside the arithmetic
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_z;
    logic signed [YAW_W-1:0] yaw;
    status_t                 status;
    logic                    moved;
    logic                    align;
    logic                    neg_x;
    logic                    neg_z;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [DIR_W-1:0]   mag_x;
    logic [DIR_W-1:0]   mag_z;
    logic [DIST_W-1:0]  travel;
  } fwd_t;

  typedef struct packed {
    logic signed [COR_W-1:0] a;
    logic signed [COR_W-1:0] b;
    logic signed [ACC_W-1:0] acc;
  } cor_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    side_t             side;
    logic [NUM_W-1:0]  num_x;
    logic [NUM_W-1:0]  num_z;
  } mid_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem_x;
    logic [DEN_W-1:0] rem_z;
    logic [Q_W-1:0]   nq_x;
    logic [Q_W-1:0]   nq_z;
  } dv_t;

  // atan(1/n) in Q0.60 by its power series; sel > 0 gives n = 2^sel,
  // sel of -5 gives n = 5 and any other value gives n = 239
  function automatic logic [ACC_W-1:0] atan_inv_q60(input int sel);
    logic [ACC_W-1:0] power;
    logic [ACC_W-1:0] sum;
    logic [ACC_W-1:0] term;
    if (sel > 0) begin
      power = (ACC_W'(1) << 60) >> sel;
    end else if (sel == -5) begin
      power = (ACC_W'(1) << 60) / 64'd5;
    end else begin
      power = (ACC_W'(1) << 60) / 64'd239;
    end
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (power != '0) begin
        term = power / ACC_W'(2 * k + 1);
        if (k[0] == 1'b0) begin
          sum = sum + term;
        end else begin
          sum = sum - term;
        end
        if (sel > 0) begin
          power = power >> (2 * sel);
        end else if (sel == -5) begin
          power = power / 64'd25;
        end else begin
          power = power / 64'd57121;
        end
      end
    end
    return sum;
  endfunction

  // Rotation angle of CORDIC stage idx in Q0.60
  function automatic logic [ACC_W-1:0] atan_q60(input int idx);
    logic [ACC_W-1:0] ang;
    if (idx == 0) begin
      ang = (atan_inv_q60(-5) << 2) - atan_inv_q60(-239);
    end else begin
      ang = atan_inv_q60(idx);
    end
    return ang;
  endfunction

  localparam logic signed [ACC_W-1:0] HALF_PI_Q60 = atan_q60(0) << 1;

endpackage

FILE: rtl/planar_direction_step.sv
`timescale 1ns / 1ps
// Planar direction step: moves a Q16.16 point in the x/z plane along a
// Q8.16 direction by speed times step, and optionally turns yaw to face it.
// Input requests arrive on in_valid/in_ready, results leave on
// out_valid/out_ready, one result per request, in order. Configuration
// registers are written on cfg_valid/cfg_ready (always ready) by index:
// 0 enabled, 1 units_per_second, 2 max_step_seconds, 3 align_yaw; write
// them only while no request is in flight.
// The pipe consists of five front-end stages, one CORDIC cell per stage,
// 32 square-root cells that resolve one root bit each, 27 divider cells
// that resolve one quotient bit for both axes each, and the output
// register. A new request is taken every cycle while in_ready is high;
// throughput is one request per cycle when the receiver does not stall.
// When the receiver stalls, the pipe keeps filling until its last cell
// holds a request; only then does in_ready drop, and it returns as soon as
// the output register is taken.
// Synchronous reset empties the pipe and loads the register defaults:
// disabled, speed 1.0, maximum step 1.0, yaw alignment off.
module planar_direction_step
  import pdstep_pkg::*;
#(
  parameter int CORDIC_STAGES = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DIR_W-1:0]  in_dir_x,
  input  logic signed [DIR_W-1:0]  in_dir_z,
  input  logic [STEP_W-1:0]        in_step_seconds,
  input  logic signed [POS_W-1:0]  in_pos_x_in,
  input  logic signed [POS_W-1:0]  in_pos_z_in,
  input  logic signed [YAW_W-1:0]  in_yaw_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  out_pos_x_out,
  output logic signed [POS_W-1:0]  out_pos_z_out,
  output logic signed [YAW_W-1:0]  out_yaw_out,
  output logic [1:0]               out_status,
  output logic                     out_moved,
  output logic                     out_saturated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [STEP_W-1:0]        cfg_data
);

  localparam logic [UPS_W-1:0]  UPS_MAX     = 20'd1024000;
  localparam logic [UPS_W-1:0]  UPS_RST     = 20'd1024;
  localparam logic [STEP_W-1:0] STEP_MAX    = 21'd1048576;
  localparam logic signed [ACC_W-1:0] YAW_HALF = ACC_W'(1) << (YAW_SH - 1);
  localparam logic signed [POS_W+1:0] POS_MAX_E = 34'sd2147483647;
  localparam logic signed [POS_W+1:0] POS_MIN_E = -34'sd2147483648;

  // Configuration registers
  logic              enabled_r;
  logic [UPS_W-1:0]  ups_r;
  logic [STEP_W-1:0] max_step_r;
  logic              align_r;

  // Flow control
  logic en;
  logic out_en;

  // Stage A: checks, raw direction, distance
  logic                    a_valid_r;
  side_t                   a_side_r;
  side_t                   a_side_nxt;
  logic signed [DIR_W-1:0] a_dx_r;
  logic signed [DIR_W-1:0] a_dz_r;
  logic [DIST_W-1:0]       a_dist_r;
  logic                    cfg_bad;
  logic                    step_bad;
  logic                    dir_nz;

  // Stage B: normalised direction
  logic                    b_valid_r;
  fwd_t                    b_fwd_r;
  fwd_t                    b_fwd_nxt;
  logic signed [DIR_W-1:0] b_dx_r;
  logic signed [DIR_W-1:0] b_dz_r;
  logic signed [DIR_W-1:0] b_dx_nxt;
  logic signed [DIR_W-1:0] b_dz_nxt;
  logic [DIR_W-1:0]        mag_x;
  logic [DIR_W-1:0]        mag_z;
  logic [DIR_W-1:0]        mag_m;
  logic [DIR_W-1:0]        m16;
  logic [DIR_W-1:0]        m8;
  logic [DIR_W-1:0]        m4;
  logic [DIR_W-1:0]        m2;
  logic [4:0]              norm_k;

  // Stage P: quadrant fold ahead of the CORDIC row
  logic                    p_valid_r;
  cor_t                    p_cor_r;
  cor_t                    p_cor_nxt;
  fwd_t                    p_fwd_r;
  logic signed [COR_W-1:0] pa;
  logic signed [COR_W-1:0] pb;

  // CORDIC row
  logic cor_v [0:CORDIC_STAGES];
  cor_t cor_c [0:CORDIC_STAGES];
  fwd_t cor_f [0:CORDIC_STAGES];

  // Stage C: yaw, squares, partial products
  logic                    c_valid_r;
  side_t                   c_side_r;
  side_t                   c_side_nxt;
  logic signed [ACC_W-1:0] yaw_sum;
  logic signed [ACC_W-1:0] yaw_q;
  logic [SQ_W-1:0]         c_sqx_r;
  logic [SQ_W-1:0]         c_sqz_r;
  logic [PPL_W-1:0]        c_ppxl_r;
  logic [PPH_W-1:0]        c_ppxh_r;
  logic [PPL_W-1:0]        c_ppzl_r;
  logic [PPH_W-1:0]        c_ppzh_r;

  // Stage D: sum of squares, full products
  logic             d_valid_r;
  logic [SQ_W-1:0]  d_s_r;
  mid_t             d_mid_r;

  // Square-root row
  logic sq_v [0:ROOT_W];
  sq_t  sq_s [0:ROOT_W];
  mid_t sq_m [0:ROOT_W];

  // Divider row
  logic  dv_v [0:Q_W];
  dv_t   dv_d [0:Q_W];
  side_t dv_s [0:Q_W];

  // Output register
  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_pos_x_r;
  logic signed [POS_W-1:0] out_pos_z_r;
  logic signed [YAW_W-1:0] out_yaw_r;
  logic [1:0]              out_status_r;
  logic                    out_moved_r;
  logic                    out_sat_r;
  logic [POS_W:0]          fin_x;
  logic [POS_W:0]          fin_z;

  // Round the quotient, apply it to the position and clip: {sat, pos}
  function automatic logic [POS_W:0] axis_move(
    input logic signed [POS_W-1:0] pos,
    input logic                    neg,
    input logic [DEN_W-1:0]        rem,
    input logic [DEN_W-1:0]        den,
    input logic [Q_W-1:0]          q
  );
    logic                    rnd;
    logic [Q_W:0]            qr;
    logic signed [POS_W+1:0] qe;
    logic signed [POS_W+1:0] pe;
    logic signed [POS_W+1:0] np;
    logic [POS_W:0]          res;
    rnd = {rem, 1'b0} >= {1'b0, den};
    qr  = (Q_W + 1)'(q) + (Q_W + 1)'(rnd);
    qe  = (POS_W + 2)'(qr);
    pe  = (POS_W + 2)'(pos);
    np  = neg ? pe - qe : pe + qe;
    if (np > POS_MAX_E) begin
      res = {1'b1, POS_MAX_E[POS_W-1:0]};
    end else if (np < POS_MIN_E) begin
      res = {1'b1, POS_MIN_E[POS_W-1:0]};
    end else begin
      res = {1'b0, np[POS_W-1:0]};
    end
    return res;
  endfunction

  // Advance the pipe unless its last cell and the output register are both stuck
  assign out_en    = !out_valid_r || out_ready;
  assign en        = !dv_v[Q_W] || out_en;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      ups_r      <= UPS_RST;
      max_step_r <= STEP_MAX;
      align_r    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLED:   enabled_r  <= cfg_data[0];
        CFG_UPS:       ups_r      <= cfg_data[UPS_W-1:0];
        CFG_MAX_STEP:  max_step_r <= cfg_data;
        CFG_ALIGN_YAW: align_r    <= cfg_data[0];
        default:       enabled_r  <= enabled_r;
      endcase
    end
  end

  // Stage A: classify the request
  always_comb begin
    cfg_bad  = !enabled_r || (ups_r == '0) || (ups_r > UPS_MAX) ||
               (max_step_r == '0) || (max_step_r > STEP_MAX);
    step_bad = in_step_seconds > max_step_r;
    dir_nz   = (in_dir_x != '0) || (in_dir_z != '0);
    a_side_nxt.pos_x = in_pos_x_in;
    a_side_nxt.pos_z = in_pos_z_in;
    a_side_nxt.yaw   = in_yaw_in;
    a_side_nxt.align = align_r;
    a_side_nxt.neg_x = in_dir_x[DIR_W-1];
    a_side_nxt.neg_z = in_dir_z[DIR_W-1];
    a_side_nxt.moved = !cfg_bad && !step_bad && dir_nz;
    if (cfg_bad) begin
      a_side_nxt.status = ST_NOT_INIT;
    end else if (step_bad) begin
      a_side_nxt.status = ST_INVALID;
    end else begin
      a_side_nxt.status = ST_OK;
    end
  end

  // Stage B: scale the direction so its larger component reaches 2^22
  always_comb begin
    mag_x  = a_dx_r[DIR_W-1] ? DIR_W'(-a_dx_r) : DIR_W'(a_dx_r);
    mag_z  = a_dz_r[DIR_W-1] ? DIR_W'(-a_dz_r) : DIR_W'(a_dz_r);
    mag_m  = (mag_x > mag_z) ? mag_x : mag_z;
    norm_k = '0;
    m16    = mag_m;
    if (mag_m[DIR_W-1 -: 17] == '0) begin
      m16       = mag_m << 16;
      norm_k[4] = 1'b1;
    end
    m8 = m16;
    if (m16[DIR_W-1 -: 9] == '0) begin
      m8        = m16 << 8;
      norm_k[3] = 1'b1;
    end
    m4 = m8;
    if (m8[DIR_W-1 -: 5] == '0) begin
      m4        = m8 << 4;
      norm_k[2] = 1'b1;
    end
    m2 = m4;
    if (m4[DIR_W-1 -: 3] == '0) begin
      m2        = m4 << 2;
      norm_k[1] = 1'b1;
    end
    if (m2[DIR_W-1 -: 2] == '0) begin
      norm_k[0] = 1'b1;
    end
    b_dx_nxt         = a_dx_r <<< norm_k;
    b_dz_nxt         = a_dz_r <<< norm_k;
    b_fwd_nxt.side   = a_side_r;
    b_fwd_nxt.mag_x  = mag_x << norm_k;
    b_fwd_nxt.mag_z  = mag_z << norm_k;
    b_fwd_nxt.travel = a_dist_r;
  end

  // Stage P: fold the left half plane onto the right one
  always_comb begin
    pb = COR_W'(b_dx_r) <<< COR_SH;
    pa = COR_W'(b_dz_r) <<< COR_SH;
    if (pa < 0) begin
      if (pb >= 0) begin
        p_cor_nxt.a   = pb;
        p_cor_nxt.b   = -pa;
        p_cor_nxt.acc = HALF_PI_Q60;
      end else begin
        p_cor_nxt.a   = -pb;
        p_cor_nxt.b   = pa;
        p_cor_nxt.acc = -HALF_PI_Q60;
      end
    end else begin
      p_cor_nxt.a   = pa;
      p_cor_nxt.b   = pb;
      p_cor_nxt.acc = '0;
    end
  end

  // Front-end valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      p_valid_r <= b_valid_r;
      c_valid_r <= cor_v[CORDIC_STAGES];
      d_valid_r <= c_valid_r;
    end
  end

  // Front-end payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= a_side_nxt;
      a_dx_r   <= in_dir_x;
      a_dz_r   <= in_dir_z;
      a_dist_r <= DIST_W'(ups_r) * DIST_W'(in_step_seconds);
      b_fwd_r  <= b_fwd_nxt;
      b_dx_r   <= b_dx_nxt;
      b_dz_r   <= b_dz_nxt;
      p_cor_r  <= p_cor_nxt;
      p_fwd_r  <= b_fwd_r;
    end
  end

  // CORDIC row
  assign cor_v[0] = p_valid_r;
  assign cor_c[0] = p_cor_r;
  assign cor_f[0] = p_fwd_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cor
    pdstep_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (cor_v[g]),
      .in_cor    (cor_c[g]),
      .in_fwd    (cor_f[g]),
      .out_valid (cor_v[g+1]),
      .out_cor   (cor_c[g+1]),
      .out_fwd   (cor_f[g+1])
    );
  end

  // Stage C: round the angle to Q3.13 and take yaw from it when a moving request aligns
  always_comb begin
    yaw_sum    = cor_c[CORDIC_STAGES].acc + YAW_HALF;
    yaw_q      = yaw_sum >>> YAW_SH;
    c_side_nxt = cor_f[CORDIC_STAGES].side;
    if (c_side_nxt.moved && c_side_nxt.align) begin
      c_side_nxt.yaw = yaw_q[YAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side_r <= c_side_nxt;
      c_sqx_r  <= SQ_W'(cor_f[CORDIC_STAGES].mag_x) * SQ_W'(cor_f[CORDIC_STAGES].mag_x);
      c_sqz_r  <= SQ_W'(cor_f[CORDIC_STAGES].mag_z) * SQ_W'(cor_f[CORDIC_STAGES].mag_z);
      c_ppxl_r <= PPL_W'(cor_f[CORDIC_STAGES].mag_x) *
                  PPL_W'(cor_f[CORDIC_STAGES].travel[DL_W-1:0]);
      c_ppxh_r <= PPH_W'(cor_f[CORDIC_STAGES].mag_x) *
                  PPH_W'(cor_f[CORDIC_STAGES].travel[DIST_W-1:DL_W]);
      c_ppzl_r <= PPL_W'(cor_f[CORDIC_STAGES].mag_z) *
                  PPL_W'(cor_f[CORDIC_STAGES].travel[DL_W-1:0]);
      c_ppzh_r <= PPH_W'(cor_f[CORDIC_STAGES].mag_z) *
                  PPH_W'(cor_f[CORDIC_STAGES].travel[DIST_W-1:DL_W]);
    end
  end

  // Stage D: combine squares and partial products
  always_ff @(posedge clk) begin
    if (en) begin
      d_s_r         <= c_sqx_r + c_sqz_r;
      d_mid_r.side  <= c_side_r;
      d_mid_r.num_x <= (NUM_W'(c_ppxh_r) << DL_W) + NUM_W'(c_ppxl_r);
      d_mid_r.num_z <= (NUM_W'(c_ppzh_r) << DL_W) + NUM_W'(c_ppzl_r);
    end
  end

  // Square-root row on the sum of squares times 2^16
  assign sq_v[0]      = d_valid_r;
  assign sq_s[0].rad  = RAD_W'(d_s_r) << RAD_SH;
  assign sq_s[0].rem  = '0;
  assign sq_s[0].root = '0;
  assign sq_m[0]      = d_mid_r;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    pdstep_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sq_v[g]),
      .in_sq     (sq_s[g]),
      .in_mid    (sq_m[g]),
      .out_valid (sq_v[g+1]),
      .out_sq    (sq_s[g+1]),
      .out_mid   (sq_m[g+1])
    );
  end

  // Divider row: both products over root times 64
  assign dv_v[0]       = sq_v[ROOT_W];
  assign dv_d[0].den   = DEN_W'(sq_s[ROOT_W].root) << DEN_SH;
  assign dv_d[0].rem_x = DEN_W'(sq_m[ROOT_W].num_x[NUM_W-1:Q_W]);
  assign dv_d[0].rem_z = DEN_W'(sq_m[ROOT_W].num_z[NUM_W-1:Q_W]);
  assign dv_d[0].nq_x  = sq_m[ROOT_W].num_x[Q_W-1:0];
  assign dv_d[0].nq_z  = sq_m[ROOT_W].num_z[Q_W-1:0];
  assign dv_s[0]       = sq_m[ROOT_W].side;

  for (genvar g = 0; g < Q_W; g++) begin : g_div
    pdstep_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv_v[g]),
      .in_dv     (dv_d[g]),
      .in_side   (dv_s[g]),
      .out_valid (dv_v[g+1]),
      .out_dv    (dv_d[g+1]),
      .out_side  (dv_s[g+1])
    );
  end

  // Final rounding, position update and clipping
  always_comb begin
    fin_x = axis_move(dv_s[Q_W].pos_x, dv_s[Q_W].neg_x, dv_d[Q_W].rem_x,
                      dv_d[Q_W].den, dv_d[Q_W].nq_x);
    fin_z = axis_move(dv_s[Q_W].pos_z, dv_s[Q_W].neg_z, dv_d[Q_W].rem_z,
                      dv_d[Q_W].den, dv_d[Q_W].nq_z);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= dv_v[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_yaw_r    <= dv_s[Q_W].yaw;
      out_status_r <= dv_s[Q_W].status;
      out_moved_r  <= dv_s[Q_W].moved;
      if (dv_s[Q_W].moved) begin
        out_pos_x_r <= fin_x[POS_W-1:0];
        out_pos_z_r <= fin_z[POS_W-1:0];
        out_sat_r   <= fin_x[POS_W] || fin_z[POS_W];
      end else begin
        out_pos_x_r <= dv_s[Q_W].pos_x;
        out_pos_z_r <= dv_s[Q_W].pos_z;
        out_sat_r   <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pos_x_out = out_pos_x_r;
  assign out_pos_z_out = out_pos_z_r;
  assign out_yaw_out   = out_yaw_r;
  assign out_status    = out_status_r;
  assign out_moved     = out_moved_r;
  assign out_saturated = out_sat_r;

`ifndef SYNTH
  a_moved_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_moved) |-> (out_status == ST_OK))
    else $error("moved result carries a failure status");

  a_sat_moved: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> out_moved)
    else $error("clip flagged on a request that did not move");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v[Q_W] && out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while the receiver stalled");
`endif

endmodule

FILE: rtl/pdstep_cordic_cell.sv
`timescale 1ns / 1ps
module pdstep_cordic_cell
  import pdstep_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  cor_t in_cor,
  input  fwd_t in_fwd,
  output logic out_valid,
  output cor_t out_cor,
  output fwd_t out_fwd
);

  localparam logic signed [ACC_W-1:0] ANGLE = atan_q60(STAGE);

  logic                    valid_r;
  cor_t                    cor_r;
  cor_t                    cor_nxt;
  fwd_t                    fwd_r;
  logic signed [COR_W-1:0] a_in;
  logic signed [COR_W-1:0] b_in;
  logic signed [COR_W-1:0] da;
  logic signed [COR_W-1:0] db;

  // Rotate towards the a axis by this stage's angle
  always_comb begin
    a_in = in_cor.a;
    b_in = in_cor.b;
    da   = b_in >>> STAGE;
    db   = a_in >>> STAGE;
    if (b_in > 0) begin
      cor_nxt.a   = a_in + da;
      cor_nxt.b   = b_in - db;
      cor_nxt.acc = in_cor.acc + ANGLE;
    end else begin
      cor_nxt.a   = a_in - da;
      cor_nxt.b   = b_in + db;
      cor_nxt.acc = in_cor.acc - ANGLE;
    end
  end

  // Hold the valid flag under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (en) begin
      cor_r <= cor_nxt;
      fwd_r <= in_fwd;
    end
  end

  assign out_valid = valid_r;
  assign out_cor   = cor_r;
  assign out_fwd   = fwd_r;

endmodule

FILE: rtl/pdstep_sqrt_cell.sv
`timescale 1ns / 1ps
module pdstep_sqrt_cell
  import pdstep_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  sq_t  in_sq,
  input  mid_t in_mid,
  output logic out_valid,
  output sq_t  out_sq,
  output mid_t out_mid
);

  logic             valid_r;
  sq_t              sq_r;
  sq_t              sq_nxt;
  mid_t             mid_r;
  logic [REM_W+1:0] rem2;
  logic [REM_W+1:0] trial;
  logic             fits;

  // Bring down two radicand bits and try one more root bit
  always_comb begin
    rem2  = {in_sq.rem, in_sq.rad[RAD_W-1 -: 2]};
    trial = {2'b00, in_sq.root, 2'b01};
    fits  = rem2 >= trial;
    sq_nxt.rad  = in_sq.rad << 2;
    sq_nxt.root = {in_sq.root[ROOT_W-2:0], fits};
    if (fits) begin
      sq_nxt.rem = REM_W'(rem2 - trial);
    end else begin
      sq_nxt.rem = REM_W'(rem2);
    end
  end

  // Hold the valid flag under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= sq_nxt;
      mid_r <= in_mid;
    end
  end

  assign out_valid = valid_r;
  assign out_sq    = sq_r;
  assign out_mid   = mid_r;

endmodule

FILE: rtl/pdstep_div_cell.sv
`timescale 1ns / 1ps
module pdstep_div_cell
  import pdstep_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  dv_t   in_dv,
  input  side_t in_side,
  output logic  out_valid,
  output dv_t   out_dv,
  output side_t out_side
);

  logic           valid_r;
  dv_t            dv_r;
  dv_t            dv_nxt;
  side_t          side_r;
  logic [DEN_W:0] rem2_x;
  logic [DEN_W:0] rem2_z;
  logic [DEN_W:0] den_e;
  logic           ge_x;
  logic           ge_z;

  // One quotient bit per lane: shift in a dividend bit, subtract if it fits
  always_comb begin
    den_e  = {1'b0, in_dv.den};
    rem2_x = {in_dv.rem_x, in_dv.nq_x[Q_W-1]};
    rem2_z = {in_dv.rem_z, in_dv.nq_z[Q_W-1]};
    ge_x   = rem2_x >= den_e;
    ge_z   = rem2_z >= den_e;
    dv_nxt.den   = in_dv.den;
    dv_nxt.rem_x = ge_x ? DEN_W'(rem2_x - den_e) : DEN_W'(rem2_x);
    dv_nxt.rem_z = ge_z ? DEN_W'(rem2_z - den_e) : DEN_W'(rem2_z);
    dv_nxt.nq_x  = {in_dv.nq_x[Q_W-2:0], ge_x};
    dv_nxt.nq_z  = {in_dv.nq_z[Q_W-2:0], ge_z};
  end

  // Hold the valid flag under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (en) begin
      dv_r   <= dv_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_dv    = dv_r;
  assign out_side  = side_r;

endmodule

FILE: tb/planar_direction_step_tb.sv
`timescale 1ns / 1ps
module planar_direction_step_tb;
  import pdstep_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;
  localparam int CORDIC_N = 20;

  typedef struct {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_z;
    logic [STEP_W-1:0]       step;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_z;
    logic signed [YAW_W-1:0] yaw;
  } step_req_t;

  typedef struct {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_z;
    logic signed [YAW_W-1:0] yaw;
    status_t                 status;
    logic                    moved;
    logic                    sat;
  } motion_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DIR_W-1:0] in_dir_x = '0;
  logic signed [DIR_W-1:0] in_dir_z = '0;
  logic [STEP_W-1:0] in_step_seconds = '0;
  logic signed [POS_W-1:0] in_pos_x_in = '0;
  logic signed [POS_W-1:0] in_pos_z_in = '0;
  logic signed [YAW_W-1:0] in_yaw_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POS_W-1:0] out_pos_x_out;
  logic signed [POS_W-1:0] out_pos_z_out;
  logic signed [YAW_W-1:0] out_yaw_out;
  logic [1:0] out_status;
  logic out_moved;
  logic out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [STEP_W-1:0] cfg_data = '0;

  // Model copy of the registers
  logic        m_enabled = 1'b0;
  logic [19:0] m_speed = 20'd1024;
  logic [20:0] m_maxstep = 21'd1048576;
  logic        m_align = 1'b0;

  step_req_t pending_reqs[$];
  motion_t   expected_motion[$];
  longint unsigned angle_rom[32];

  logic in_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int idle_cycles = 0;
  int n_results = 0;
  int n_moved = 0;
  int n_mismatch = 0;
  int n_phases = 0;

  planar_direction_step dut (.*);

  always #10 clk = ~clk;

  // atan(1/n) in Q0.60 by its alternating series
  function automatic longint unsigned atan_recip(longint unsigned n);
    longint unsigned pw, sum, k;
    pw = (64'd1 << 60) / n;
    sum = 0;
    k = 0;
    while (pw != 0) begin
      if (k[0] == 1'b0) sum += pw / (2 * k + 1);
      else sum -= pw / (2 * k + 1);
      pw = pw / (n * n);
      k++;
    end
    return sum;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Heading atan2(b, a) in Q3.60
  function automatic longint heading_q60(longint b, longint a);
    longint acc, t, da, db;
    acc = 0;
    if (a < 0) begin
      if (b >= 0) begin
        t = a; a = b; b = -t; acc = 2 * longint'(angle_rom[0]);
      end else begin
        t = a; a = -b; b = t; acc = -2 * longint'(angle_rom[0]);
      end
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b > 0) begin
        a += da; b -= db; acc += longint'(angle_rom[i]);
      end else begin
        a -= da; b += db; acc -= longint'(angle_rom[i]);
      end
    end
    return acc;
  endfunction

  function automatic longint shift_axis(longint pos, longint comp,
                                        longint unsigned travel,
                                        longint unsigned den, inout logic sat);
    longint unsigned mag, num, q, r;
    longint np;
    mag = comp < 0 ? -comp : comp;
    num = mag * travel;
    q = num / den;
    r = num % den;
    if (2 * r >= den) q++;
    np = comp < 0 ? pos - longint'(q) : pos + longint'(q);
    if (np > 64'sd2147483647) begin sat = 1'b1; np = 64'sd2147483647; end
    if (np < -64'sd2147483648) begin sat = 1'b1; np = -64'sd2147483648; end
    return np;
  endfunction

  function automatic motion_t predict_motion(step_req_t r);
    motion_t res;
    longint dx, dz, sc;
    longint unsigned ax, az, mx, s, rt, travel;
    logic sat;
    res.pos_x = r.pos_x;
    res.pos_z = r.pos_z;
    res.yaw = r.yaw;
    res.status = ST_OK;
    res.moved = 1'b0;
    sat = 1'b0;
    dx = r.dir_x;
    dz = r.dir_z;
    if (!m_enabled || m_speed == 0 || m_speed > 1024000 || m_maxstep == 0 ||
        m_maxstep > 1048576) begin
      res.status = ST_NOT_INIT;
    end else if (r.step > m_maxstep) begin
      res.status = ST_INVALID;
    end else if (dx != 0 || dz != 0) begin
      ax = dx < 0 ? -dx : dx;
      az = dz < 0 ? -dz : dz;
      mx = ax > az ? ax : az;
      sc = 1;
      while (mx < (64'd1 << 22)) begin mx <<= 1; sc *= 2; end
      dx *= sc;
      dz *= sc;
      s = longint'(dx * dx) + longint'(dz * dz);
      rt = root64(s << 16);
      travel = longint'(m_speed) * longint'(r.step);
      res.pos_x = POS_W'(shift_axis(r.pos_x, dx, travel, rt * 64, sat));
      res.pos_z = POS_W'(shift_axis(r.pos_z, dz, travel, rt * 64, sat));
      if (m_align)
        res.yaw = YAW_W'((heading_q60(dx * 131072, dz * 131072) +
                          (64'sd1 <<< 46)) >>> 47);
      res.moved = 1'b1;
    end
    res.sat = sat;
    return res;
  endfunction

  function automatic step_req_t rand_req(int unsigned maxstep);
    step_req_t r;
    int unsigned k;
    k = $urandom_range(0, 9);
    r.dir_x = DIR_W'($urandom);
    r.dir_z = DIR_W'($urandom);
    if (k == 0) r.dir_x = '0;
    if (k == 1) r.dir_z = '0;
    if (k == 2) begin r.dir_x = '0; r.dir_z = '0; end
    if (k == 3) begin
      r.dir_x = DIR_W'($signed($urandom_range(0, 255)) - 128);
      r.dir_z = DIR_W'($signed($urandom_range(0, 255)) - 128);
    end
    k = $urandom_range(0, 9);
    if (k == 0) r.step = '0;
    else if (k == 1) r.step = STEP_W'($urandom);
    else if (k == 2) r.step = STEP_W'(maxstep);
    else r.step = STEP_W'($urandom_range(0, maxstep > 1048576 ? 1048576 : maxstep));
    r.pos_x = $urandom;
    r.pos_z = $urandom;
    if ($urandom_range(0, 4) == 0) r.pos_x = {r.pos_x[31], {5{~r.pos_x[31]}}, r.pos_x[25:0]};
    if ($urandom_range(0, 4) == 0) r.pos_z = {r.pos_z[31], {5{~r.pos_z[31]}}, r.pos_z[25:0]};
    r.yaw = YAW_W'($urandom);
    return r;
  endfunction

  function automatic step_req_t mk_req(int dxv, int dzv, int unsigned st, int pxv,
                                       int pzv, int yv);
    step_req_t r;
    r.dir_x = DIR_W'(dxv); r.dir_z = DIR_W'(dzv); r.step = STEP_W'(st);
    r.pos_x = pxv; r.pos_z = pzv; r.yaw = YAW_W'(yv);
    return r;
  endfunction

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= STEP_W'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_motion.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic setup_phase(bit en, int unsigned spd, int unsigned mstep, bit al);
    wait_idle();
    write_reg(CFG_ENABLED, en);
    write_reg(CFG_UPS, spd);
    write_reg(CFG_MAX_STEP, mstep);
    write_reg(CFG_ALIGN_YAW, al);
    n_phases++;
  endtask

  // Sender: bursts of requests with random gaps
  always @(negedge clk) begin
    step_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_dir_x <= r.dir_x;
        in_dir_z <= r.dir_z;
        in_step_seconds <= r.step;
        in_pos_x_in <= r.pos_x;
        in_pos_z_in <= r.pos_z;
        in_yaw_in <= r.yaw;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changes every stretch
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 300);
    end
    mode_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    step_req_t r;
    motion_t exp_m;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ENABLED:   m_enabled <= cfg_data[0];
          CFG_UPS:       m_speed <= cfg_data[19:0];
          CFG_MAX_STEP:  m_maxstep <= cfg_data;
          CFG_ALIGN_YAW: m_align <= cfg_data[0];
        endcase
      end
      if (in_valid && in_ready) begin
        r.dir_x = in_dir_x; r.dir_z = in_dir_z; r.step = in_step_seconds;
        r.pos_x = in_pos_x_in; r.pos_z = in_pos_z_in; r.yaw = in_yaw_in;
        expected_motion.push_back(predict_motion(r));
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_motion.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("result with no request waiting");
        end else begin
          exp_m = expected_motion.pop_front();
          if (out_moved) n_moved++;
          if (out_pos_x_out !== exp_m.pos_x || out_pos_z_out !== exp_m.pos_z ||
              out_yaw_out !== exp_m.yaw || out_status !== exp_m.status ||
              out_moved !== exp_m.moved || out_saturated !== exp_m.sat) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("mismatch #%0d: exp x=%0d z=%0d yaw=%0d st=%0d mv=%0b sat=%0b",
                       n_results, exp_m.pos_x, exp_m.pos_z, exp_m.yaw, exp_m.status,
                       exp_m.moved, exp_m.sat);
              $display("  got x=%0d z=%0d yaw=%0d st=%0d mv=%0b sat=%0b",
                       out_pos_x_out, out_pos_z_out, out_yaw_out,
                       out_status, out_moved, out_saturated);
            end
          end
        end
      end
    end
  end

  // Watchdog on progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[planar_direction_step] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned speeds[8];
    int unsigned msteps[8];
    bit          aligns[8];
    angle_rom[0] = 4 * atan_recip(5) - atan_recip(239);
    for (int i = 1; i < 32; i++) angle_rom[i] = atan_recip(64'd1 << i);
    speeds = '{1024000, 1, 1024, 512000, 1024000, 0, 3000, 777};
    msteps = '{1048576, 1048576, 1, 524288, 2097151, 1048576, 1048576, 1048576};
    aligns = '{1, 0, 1, 1, 1, 1, 0, 1};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Disabled after reset: outputs echo the inputs
    pending_reqs.push_back(mk_req(65536, 0, 1000, 5, 6, 7));
    pending_reqs.push_back(mk_req(-8388608, 8388607, 1048576, -1, 1, -32768));

    setup_phase(1, 1024000, 1048576, 1);
    pending_reqs.push_back(mk_req(8388607, 8388607, 1048576, 2147483647, 2147483647, 32767));
    pending_reqs.push_back(mk_req(-8388608, -8388608, 1048576, -2147483647 - 1,
                                  -2147483647 - 1, -32768));
    pending_reqs.push_back(mk_req(0, 0, 500000, 123, 456, 789));
    pending_reqs.push_back(mk_req(65536, 65536, 0, 10, 20, 30));
    pending_reqs.push_back(mk_req(0, -65536, 1000, 0, 0, 0));
    pending_reqs.push_back(mk_req(0, 65536, 1000, 0, 0, 0));
    pending_reqs.push_back(mk_req(65536, 0, 1000, 0, 0, 0));
    pending_reqs.push_back(mk_req(-65536, 0, 1000, 0, 0, 0));
    pending_reqs.push_back(mk_req(1, 0, 1048576, 2147000000, 0, 0));
    pending_reqs.push_back(mk_req(0, -1, 1048576, 0, -2147000000, 0));
    pending_reqs.push_back(mk_req(-1, -1, 1048576, 0, 0, 0));
    pending_reqs.push_back(mk_req(100, 200, 2097151, 1, 2, 3));
    pending_reqs.push_back(mk_req(-8388608, 0, 777777, 0, 0, 0));
    pending_reqs.push_back(mk_req(0, -8388608, 777777, 0, 0, 0));

    setup_phase(1, 1024, 1000, 0);
    pending_reqs.push_back(mk_req(65536, 65536, 1000, 1, 1, 1));
    pending_reqs.push_back(mk_req(65536, 65536, 1001, 1, 1, 1));

    // Random phases over a spread of settings
    for (int p = 0; p < 8; p++) begin
      setup_phase(p != 6 || $urandom_range(0, 1), speeds[p], msteps[p], aligns[p]);
      for (int i = 0; i < 100; i++) pending_reqs.push_back(rand_req(msteps[p]));
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d results (%0d moved) over %0d register settings",
             n_results, n_moved, n_phases + 1);
    if (n_mismatch == 0 && expected_motion.size() == 0) begin
      $display("[planar_direction_step] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, expected_motion.size());
      $display("[planar_direction_step] ERROR");
    end
    $finish;
  end

endmodule
